/* rtl/core/glyph_run_length_decoder_defines.svh */
// Assertion macros shared by the glyph run-length decoder checkers.
`ifndef GLYPH_RUN_LENGTH_DECODER_DEFINES_SVH
`define GLYPH_RUN_LENGTH_DECODER_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define GRLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph decoder check failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define GRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph decoder check failed");

`endif

/* rtl/core/grld_pkg.sv */
// Package with types, codes and the alpha table of the glyph run-length decoder.
`default_nettype none

package grld_pkg;

    localparam int DEF_COUNT_BITS = 16;
    localparam int VALUE_W        = 8;
    localparam int INDEX_W        = 16;
    localparam int TOTAL_W        = 16;
    localparam int RUN_A_W        = 5;
    localparam int RUN_B_W        = 3;
    localparam int EXPAND_W       = 6;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [7:0] MODE_MONO = 8'h01;
    localparam logic [7:0] MODE_AA   = 8'h03;

    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_MODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_TOTAL = 1'b1;

    localparam logic [1:0] CODE_RUN      = 2'd0;
    localparam logic [1:0] CODE_RUN_EDGE = 2'd1;
    localparam logic [1:0] CODE_RUN_WIDE = 2'd2;
    localparam logic [1:0] CODE_PAIR     = 2'd3;

    localparam logic [VALUE_W-1:0] GREY_CLEAR  = 8'h00;
    localparam logic [VALUE_W-1:0] GREY_OPAQUE = 8'hFF;

    // One code byte splits into a first run and a second run.
    typedef struct packed {
        logic                 mode_ok;
        logic [RUN_A_W-1:0]   run_a;
        logic [VALUE_W-1:0]   val_a;
        logic [RUN_B_W-1:0]   run_b;
        logic [VALUE_W-1:0]   val_b;
    } grld_dec_t;

    // Scales a 3-bit alpha to eight bits as (v*255+3)/7.
    function automatic logic [VALUE_W-1:0] alpha3_to_8(input logic [2:0] v);
        logic [VALUE_W-1:0] r;
        case (v)
            3'd0:    r = 8'd0;
            3'd1:    r = 8'd36;
            3'd2:    r = 8'd73;
            3'd3:    r = 8'd109;
            3'd4:    r = 8'd146;
            3'd5:    r = 8'd182;
            3'd6:    r = 8'd219;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/grld_decode.sv */
// Code byte decoder: splits one byte into two runs with their grey levels.
`default_nettype none

module grld_decode
    import grld_pkg::*;
(
    input  wire logic [7:0] code_byte,
    input  wire logic [7:0] glyph_mode,
    output grld_dec_t       dec
);

    logic [1:0] code;
    logic       flag;
    logic [4:0] cnt;
    logic [2:0] hi3;
    logic [2:0] lo3;

    assign code = code_byte[7:6];
    assign flag = code_byte[5];
    assign cnt  = code_byte[4:0];
    assign hi3  = code_byte[5:3];
    assign lo3  = code_byte[2:0];

    always_comb
    begin
        dec         = '0;
        dec.mode_ok = 1'b1;
        if (glyph_mode == MODE_AA)
        begin
            unique case (code)
                CODE_RUN:
                begin
                    dec.run_a = cnt;
                    dec.val_a = flag ? GREY_OPAQUE : GREY_CLEAR;
                end
                CODE_RUN_EDGE:
                begin
                    dec.run_a = cnt;
                    dec.run_b = flag ? 3'd2 : 3'd1;
                    dec.val_b = GREY_OPAQUE;
                end
                CODE_RUN_WIDE:
                begin
                    dec.run_a = RUN_A_W'(hi3);
                    dec.run_b = 3'd1;
                    dec.val_b = alpha3_to_8(lo3);
                end
                default:
                begin
                    dec.run_a = 5'd1;
                    dec.val_a = alpha3_to_8(hi3);
                    dec.run_b = 3'd1;
                    dec.val_b = alpha3_to_8(lo3);
                end
            endcase
        end
        else if (glyph_mode == MODE_MONO)
        begin
            unique case (code)
                CODE_RUN:
                begin
                    dec.run_a = cnt;
                    dec.val_a = flag ? GREY_OPAQUE : GREY_CLEAR;
                end
                CODE_RUN_EDGE:
                begin
                    dec.run_a = cnt;
                    dec.run_b = flag ? 3'd2 : 3'd1;
                    dec.val_b = GREY_OPAQUE;
                end
                CODE_RUN_WIDE:
                begin
                    dec.run_a = cnt;
                    dec.run_b = flag ? 3'd4 : 3'd3;
                    dec.val_b = GREY_OPAQUE;
                end
                default:
                begin
                    dec.run_a = RUN_A_W'(hi3);
                    dec.run_b = lo3;
                    dec.val_b = GREY_OPAQUE;
                end
            endcase
        end
        else
        begin
            dec.mode_ok = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/glyph_run_length_decoder.sv */
// Top level of the glyph run-length decoder: state, run expander and output register.
`default_nettype none

// The decoder turns a stream of glyph code bytes into 8-bit grey pixels. A
// beat with tuser 0 starts a new glyph and clears the pixel counter; a beat
// with tuser 1 carries one code byte, which is decoded in the cycle it is
// taken and expands into zero to 35 pixel beats. Pixels leave at one per
// cycle while the receiver is ready, through a registered output; the run
// expander is busy with a byte up to its end; the next byte is taken in the
// cycle the expander hands over its final pixel; bytes that yield nothing
// (start beats, empty codes, bytes after the glyph is complete or after a
// mode error) are taken once per cycle while the expander is free. Output
// stops at pixel_total (limited to what COUNT_BITS bits hold). When
// glyph_mode is neither anti-aliased nor mono, the first byte of the glyph
// gives one beat with tuser 1 and value 0, and the rest of the glyph gives
// nothing. Configuration writes are always taken and must only be issued
// while the decoder has nothing in flight.

module glyph_run_length_decoder
    import grld_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] code_byte
    input  wire logic                   s_axis_tuser,   // [0] kind

    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output      logic [23:0]            m_axis_tdata,   // [7:0] pixel_value, [23:8] pixel_index
    output      logic                   m_axis_tlast,
    output      logic                   m_axis_tuser,   // [0] status

    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TOTAL_W-1:0]     cfg_data
);

    // Width wide enough for both the configured total and the counter limit.
    localparam int CMP_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

    // Configuration registers.
    logic [7:0]            glyph_mode_reg;
    logic [TOTAL_W-1:0]    pixel_total_reg;

    // Glyph state.
    logic [COUNT_BITS-1:0] pixels_written_reg, pixels_written_next;
    logic                  mode_error_reg, mode_error_next;

    // Run expander: the job of the code byte currently being emitted.
    logic                  job_valid_reg, job_valid_next;
    logic [EXPAND_W-1:0]   job_pos_reg, job_pos_next;
    logic [EXPAND_W-1:0]   job_len_reg, job_len_next;
    logic [EXPAND_W-1:0]   job_split_reg, job_split_next;
    logic [VALUE_W-1:0]    job_val_a_reg, job_val_a_next;
    logic [VALUE_W-1:0]    job_val_b_reg, job_val_b_next;
    logic [COUNT_BITS-1:0] job_index_reg, job_index_next;
    logic                  job_err_reg, job_err_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [INDEX_W-1:0]    out_index_reg, out_index_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_status_reg, out_status_next;

    grld_dec_t             dec;
    logic [CMP_W-1:0]      total_wide;
    logic [CMP_W-1:0]      limit_wide;
    logic [COUNT_BITS-1:0] total_eff;
    logic [COUNT_BITS-1:0] remaining;
    logic                  glyph_done;
    logic                  glyph_active;
    logic [EXPAND_W-1:0]   run_sum;
    logic [EXPAND_W-1:0]   emit_len;
    logic                  in_fire;
    logic                  load_job;
    logic                  load_out;
    logic                  pix_last;

    grld_decode u_decode (
        .code_byte  (s_axis_tdata),
        .glyph_mode (glyph_mode_reg),
        .dec        (dec)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_mode_reg  <= MODE_AA;
            pixel_total_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GLYPH_MODE:  glyph_mode_reg  <= cfg_data[7:0];
                REG_PIXEL_TOTAL: pixel_total_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // The usable total is the configured one, capped at the counter's range.
    always_comb
    begin
        total_wide = CMP_W'(pixel_total_reg);
        limit_wide = CMP_W'({COUNT_BITS{1'b1}});
        total_eff  = (total_wide < limit_wide) ? COUNT_BITS'(total_wide)
                                               : COUNT_BITS'(limit_wide);
    end

    assign glyph_done   = (pixels_written_reg >= total_eff);
    assign glyph_active = !mode_error_reg && !glyph_done;
    assign remaining    = total_eff - pixels_written_reg;
    assign run_sum      = EXPAND_W'(dec.run_a) + EXPAND_W'(dec.run_b);
    // Pixels past the total are dropped, so the run may be cut short.
    assign emit_len     = (remaining < COUNT_BITS'(run_sum)) ? remaining[EXPAND_W-1:0]
                                                             : run_sum;

    // The expander's current pixel and its hand-off to the output register.
    assign pix_last = (job_pos_reg == job_len_reg - EXPAND_W'(1));
    assign load_out = job_valid_reg && (!out_valid_reg || m_axis_tready);

    // A new byte is taken once the expander is free or gives up its final pixel.
    assign s_axis_tready = !job_valid_reg || (load_out && pix_last);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_job      = in_fire && s_axis_tuser && glyph_active
                           && (!dec.mode_ok || (emit_len != '0));

    always_comb
    begin
        pixels_written_next = pixels_written_reg;
        mode_error_next     = mode_error_reg;
        if (in_fire)
        begin
            if (!s_axis_tuser)
            begin
                pixels_written_next = '0;
                mode_error_next     = 1'b0;
            end
            else if (glyph_active)
            begin
                if (dec.mode_ok)
                begin
                    pixels_written_next = pixels_written_reg + COUNT_BITS'(emit_len);
                end
                else
                begin
                    mode_error_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_pos_next   = job_pos_reg;
        job_len_next   = job_len_reg;
        job_split_next = job_split_reg;
        job_val_a_next = job_val_a_reg;
        job_val_b_next = job_val_b_reg;
        job_index_next = job_index_reg;
        job_err_next   = job_err_reg;
        if (load_out)
        begin
            job_pos_next   = job_pos_reg + EXPAND_W'(1);
            job_index_next = job_index_reg + COUNT_BITS'(1);
            if (pix_last)
            begin
                job_valid_next = 1'b0;
            end
        end
        if (load_job)
        begin
            job_valid_next = 1'b1;
            job_pos_next   = '0;
            job_len_next   = dec.mode_ok ? emit_len : EXPAND_W'(1);
            job_split_next = EXPAND_W'(dec.run_a);
            job_val_a_next = dec.val_a;
            job_val_b_next = dec.val_b;
            job_index_next = pixels_written_reg;
            job_err_next   = !dec.mode_ok;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = (job_pos_reg < job_split_reg) ? job_val_a_reg : job_val_b_reg;
            out_index_next  = INDEX_W'(job_index_reg);
            out_last_next   = pix_last;
            out_status_next = job_err_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_written_reg <= '0;
            mode_error_reg     <= 1'b0;
            job_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            pixels_written_reg <= pixels_written_next;
            mode_error_reg     <= mode_error_next;
            job_valid_reg      <= job_valid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        job_pos_reg    <= job_pos_next;
        job_len_reg    <= job_len_next;
        job_split_reg  <= job_split_next;
        job_val_a_reg  <= job_val_a_next;
        job_val_b_reg  <= job_val_b_next;
        job_index_reg  <= job_index_next;
        job_err_reg    <= job_err_next;
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_index_reg, out_value_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

/* rtl/core/grld_checker.sv */
// Port-level checker for the glyph run-length decoder and its bind statement.
`default_nettype none

`include "glyph_run_length_decoder_defines.svh"

module grld_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);

    logic        out_wait;
    logic        err_beat;
    logic        run_more;
    logic [7:0]  pix;
    logic [15:0] idx;
    logic [15:0] idx_inc;

    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign err_beat = m_axis_tvalid && m_axis_tuser;
    assign run_more = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign pix      = m_axis_tdata[7:0];
    assign idx      = m_axis_tdata[23:8];
    assign idx_inc  = idx + 16'd1;

    // A stalled output beat stays up with the same payload.
    `GRLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata))

    // An error beat stands alone: it closes its byte and carries a clear pixel.
    `GRLD_ASSERT_SAME(a_error_beat, clk, rst_n, err_beat, m_axis_tlast && (pix == 8'h00))

    // Within one byte the pixels follow back to back at consecutive positions.
    `GRLD_ASSERT_NEXT(a_run_step, clk, rst_n, run_more, m_axis_tvalid && (idx == $past(idx_inc)))

endmodule

bind glyph_run_length_decoder grld_checker u_grld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* dv/glyph_pixel_checker.sv */
// Pixel stream checker for the glyph run-length decoder, with the beat kinds it shares with the top.

package glyph_tb_pkg;

    // What the tuser bit of an input beat says about its data.
    typedef enum logic {
        KIND_START = 1'b0,
        KIND_CODE  = 1'b1
    } beat_kind_t;

endpackage

module glyph_pixel_checker
    import grld_pkg::*;
    import glyph_tb_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [23:0]            m_axis_tdata,
    input  logic                   m_axis_tlast,
    input  logic                   m_axis_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TOTAL_W-1:0]     cfg_data,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STATUS_PIXEL    = 1'b0;
    localparam logic STATUS_BAD_MODE = 1'b1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               status;
    } pixel_beat_t;

    logic [7:0]            mode_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [COUNT_BITS-1:0] pixels_done;
    logic                  glyph_faulted;
    pixel_beat_t           pixel_expect_q[$];

    function automatic logic [VALUE_W-1:0] scale_alpha(input logic [2:0] v);
        return VALUE_W'((int'(v) * 255 + 3) / 7);
    endfunction

    // Pixels past the glyph's end are simply dropped.
    task automatic emit_pixel(input logic [VALUE_W-1:0] value, input int cap);
        pixel_beat_t beat;
        if (int'(pixels_done) >= cap)
            return;
        beat.value  = value;
        beat.index  = INDEX_W'(pixels_done);
        beat.last   = 1'b0;
        beat.status = STATUS_PIXEL;
        pixel_expect_q.push_back(beat);
        pixels_done = pixels_done + COUNT_BITS'(1);
    endtask

    task automatic emit_run(input int count, input logic [VALUE_W-1:0] value, input int cap);
        for (int k = 0; k < count; k++)
            emit_pixel(value, cap);
    endtask

    task automatic decode_code_byte(input logic [7:0] code_byte);
        logic [1:0]         code;
        logic               flag;
        int                 run;
        logic [2:0]         hi3;
        logic [2:0]         lo3;
        int                 cap;
        int                 first;
        logic [VALUE_W-1:0] run_grey;
        pixel_beat_t        fault;

        code     = code_byte[7:6];
        flag     = code_byte[5];
        run      = int'(code_byte[4:0]);
        hi3      = code_byte[5:3];
        lo3      = code_byte[2:0];
        run_grey = flag ? GREY_OPAQUE : GREY_CLEAR;
        // The counter cannot go past what COUNT_BITS bits hold.
        cap = (int'(total_reg) < int'(COUNT_MAX)) ? int'(total_reg) : int'(COUNT_MAX);

        if (glyph_faulted || int'(pixels_done) >= cap)
            return;
        first = pixel_expect_q.size();

        if (mode_reg == MODE_AA)
        begin
            case (code)
                CODE_RUN: emit_run(run, run_grey, cap);
                CODE_RUN_EDGE:
                begin
                    emit_run(run, GREY_CLEAR, cap);
                    emit_run(flag ? 2 : 1, GREY_OPAQUE, cap);
                end
                CODE_RUN_WIDE:
                begin
                    emit_run(int'(hi3), GREY_CLEAR, cap);
                    emit_pixel(scale_alpha(lo3), cap);
                end
                default:
                begin
                    emit_pixel(scale_alpha(hi3), cap);
                    emit_pixel(scale_alpha(lo3), cap);
                end
            endcase
        end
        else if (mode_reg == MODE_MONO)
        begin
            case (code)
                CODE_RUN: emit_run(run, run_grey, cap);
                CODE_RUN_EDGE:
                begin
                    emit_run(run, GREY_CLEAR, cap);
                    emit_run(flag ? 2 : 1, GREY_OPAQUE, cap);
                end
                CODE_RUN_WIDE:
                begin
                    emit_run(run, GREY_CLEAR, cap);
                    emit_run(flag ? 4 : 3, GREY_OPAQUE, cap);
                end
                default:
                begin
                    emit_run(int'(hi3), GREY_CLEAR, cap);
                    emit_run(int'(lo3), GREY_OPAQUE, cap);
                end
            endcase
        end
        else
        begin
            // One error beat, then the rest of the glyph is dropped.
            fault.value  = GREY_CLEAR;
            fault.index  = INDEX_W'(pixels_done);
            fault.last   = 1'b1;
            fault.status = STATUS_BAD_MODE;
            pixel_expect_q.push_back(fault);
            glyph_faulted = 1'b1;
            return;
        end

        if (pixel_expect_q.size() > first)
            pixel_expect_q[pixel_expect_q.size() - 1].last = 1'b1;
    endtask

    // Output beats are compared before the input of the same edge is decoded,
    // since an output beat always belongs to an older code byte.
    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_beat_t want;
        string       got;
        if (!rst_n)
        begin
            mode_reg      = MODE_AA;
            total_reg     = '0;
            pixels_done   = '0;
            glyph_faulted = 1'b0;
            pixel_expect_q.delete();
            mismatches    = 0;
            outstanding   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = $sformatf("value %0d index %0d last %0b status %0b",
                                m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast,
                                m_axis_tuser);
                if (pixel_expect_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected pixel beat, expected none, got %s", $time, got);
                end
                else
                begin
                    want = pixel_expect_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.value || m_axis_tdata[23:8] !== want.index ||
                        m_axis_tlast !== want.last || m_axis_tuser !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: pixel mismatch, expected %s, got %s", $time,
                                 $sformatf("value %0d index %0d last %0b status %0b",
                                           want.value, want.index, want.last, want.status),
                                 got);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GLYPH_MODE:  mode_reg  = cfg_data[7:0];
                    REG_PIXEL_TOTAL: total_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == KIND_START)
                begin
                    pixels_done   = '0;
                    glyph_faulted = 1'b0;
                end
                else
                begin
                    decode_code_byte(s_axis_tdata);
                end
            end
            outstanding = pixel_expect_q.size();
        end
    end

endmodule

/* dv/testbench.sv */
// Testbench top for the glyph run-length decoder: stimulus, pacing, watchdog and verdict.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import grld_pkg::*;
    import glyph_tb_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    // The decoder registers its output; a byte that yields nothing leaves no work
    // behind once taken, and the settle pause covers it before a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 96;
    // Longest quiet stretch of a correct run: the longest receiver stall or the
    // longest sender gap, plus the settle pause. Several times over.
    localparam int QUIET_LIMIT   = 5000;

    logic                   clk = 1'b0;
    logic                   rst_n;

    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] code_byte
    logic                   s_axis_tuser;   // [0] kind

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [23:0]            m_axis_tdata;   // [7:0] pixel_value, [23:8] pixel_index
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;   // [0] status

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TOTAL_W-1:0]     cfg_data;

    int                     pixel_mismatches;
    int                     pixels_pending;

    // When set, neither the sender nor the receiver idles.
    logic                   no_idle = 1'b0;
    int                     stall_left = 0;

    always #(CLK_HALF) clk = ~clk;

    glyph_run_length_decoder #(
        .COUNT_BITS (DEF_COUNT_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    glyph_pixel_checker #(
        .COUNT_BITS (DEF_COUNT_BITS)
    ) pixel_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (pixel_mismatches),
        .outstanding   (pixels_pending)
    );

    // Receiver pacing. Most cycles accept; short stalls are common and a few
    // long ones hold the pixel stream back.
    always @(negedge clk)
    begin : pixel_pacing
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= (roll >= 25);
            if (roll < 4)
                stall_left <= $urandom_range(10, 40);
            else if (roll < 25)
                stall_left <= $urandom_range(0, 2);
        end
    end

    // Sender gap after a beat: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Entered at a falling edge. tvalid is left high when no gap follows, so
    // back-to-back beats never lower and raise it within one time step.
    task automatic send_beat(input beat_kind_t kind, input logic [7:0] code);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= code;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Writes both registers back to back. The upper byte of the mode write is
    // random, since only the low byte is meant to count.
    task automatic set_glyph(input logic [7:0] mode, input logic [TOTAL_W-1:0] total);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GLYPH_MODE;
        cfg_data  <= {8'($urandom_range(0, 255)), mode};
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= REG_PIXEL_TOTAL;
        cfg_data  <= total;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops the byte stream and waits for every predicted pixel to come out,
    // then lets bytes that yield nothing finish inside the decoder.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pixels_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Watchdog: a run in which nothing moves on any channel for too long has hung.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]         mode;
        logic [TOTAL_W-1:0] total;
        int                 nbytes;
        int                 sent_items;
        int                 roll;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_START;
        cfg_valid     = 1'b0;
        cfg_index     = REG_GLYPH_MODE;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Out of reset the pixel total is zero, so the glyph is already
        // complete and a code byte gives nothing.
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_CODE, 8'h3F);
        wait_drained();

        // Anti-aliased glyph: every code with its field extremes, then a run
        // cut short at the pixel total and a byte after the glyph is complete.
        set_glyph(MODE_AA, 16'd120);
        send_beat(KIND_START, 8'hFF);
        send_beat(KIND_CODE, 8'h00);    // empty run
        send_beat(KIND_CODE, 8'h3F);    // 31 opaque
        send_beat(KIND_CODE, 8'h1F);    // 31 clear
        send_beat(KIND_CODE, 8'h40);    // one opaque edge pixel
        send_beat(KIND_CODE, 8'h7F);    // 31 clear, two opaque
        send_beat(KIND_CODE, 8'h80);    // alpha zero alone
        send_beat(KIND_CODE, 8'hBF);    // 7 clear, full alpha
        send_beat(KIND_CODE, 8'hC0);    // two zero alphas
        send_beat(KIND_CODE, 8'hFF);    // two full alphas
        send_beat(KIND_CODE, 8'hD1);    // two middle alphas
        send_beat(KIND_CODE, 8'h3F);    // truncated at the total
        send_beat(KIND_CODE, 8'h3F);    // glyph complete, nothing
        wait_drained();

        // Mono glyph: the widest code gives 35 pixels, and an empty pair code.
        set_glyph(MODE_MONO, 16'd300);
        send_beat(KIND_START, 8'h00);
        send_beat(KIND_CODE, 8'hBF);
        send_beat(KIND_CODE, 8'h80);
        send_beat(KIND_CODE, 8'hC0);
        send_beat(KIND_CODE, 8'hFF);
        send_beat(KIND_CODE, 8'h7F);
        send_beat(KIND_CODE, 8'h40);
        wait_drained();

        // Unknown mode with the largest total: one error beat, then silence.
        set_glyph(8'hFF, 16'hFFFF);
        send_beat(KIND_START, 8'h5A);
        send_beat(KIND_CODE, 8'h3F);
        send_beat(KIND_CODE, 8'hA5);
        wait_drained();

        // Random glyphs. Most are well formed: registers set, a start beat,
        // then random code bytes. Some skip the start so the pixel count runs
        // on from the glyph before, and some restart in the middle.
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 45)
                mode = MODE_AA;
            else if (roll < 90)
                mode = MODE_MONO;
            else if (roll < 94)
                mode = 8'h00;
            else
                mode = 8'($urandom_range(0, 255));

            roll = $urandom_range(0, 99);
            if (roll < 80)
                total = TOTAL_W'($urandom_range(1, 150));
            else if (roll < 88)
                total = '0;
            else if (roll < 95)
                total = TOTAL_W'($urandom_range(151, 600));
            else if (roll < 98)
                total = 16'd65025;
            else
                total = 16'hFFFF;
            set_glyph(mode, total);
            no_idle <= ($urandom_range(0, 3) == 0);

            if ($urandom_range(0, 99) < 85)
            begin
                send_beat(KIND_START, 8'($urandom_range(0, 255)));
                sent_items++;
            end
            nbytes = $urandom_range(2, 12);
            for (int n = 0; n < nbytes; n++)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_beat(KIND_START, 8'($urandom_range(0, 255)));
                else
                    send_beat(KIND_CODE, 8'($urandom_range(0, 255)));
                sent_items++;
            end
        end
        wait_drained();

        if (pixel_mismatches == 0 && pixels_pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* glyph_run_length_decoder.f */
+incdir+rtl/core
rtl/core/grld_pkg.sv
rtl/core/grld_decode.sv
rtl/core/glyph_run_length_decoder.sv
rtl/core/grld_checker.sv
dv/glyph_pixel_checker.sv
dv/testbench.sv
